[rtl/efws_pkg.sv]
// Package: sizes, payload structs and chain control types for the scheduler.
`timescale 1ns / 1ps
`default_nettype none
package efws_pkg;

  localparam int MAX_WORKERS = 64;
  localparam int TIME_BITS   = 48;
  localparam int IDX_BITS    = $clog2(MAX_WORKERS);
  localparam int CNT_BITS    = $clog2(MAX_WORKERS + 1);
  localparam int DUR_BITS    = 32;
  localparam int NW_BITS     = 7;
  localparam int WORKER_BITS = 6;
  localparam int START_BITS  = 48;

  typedef struct packed {
    logic [DUR_BITS-1:0] duration;
    logic                first_of_batch;
  } in_t;

  typedef struct packed {
    logic [WORKER_BITS-1:0] worker;
    logic [START_BITS-1:0]  start_time;
  } out_t;

  // Search token walking down the chain: best free time seen so far.
  typedef struct packed {
    logic                 vld;
    logic [TIME_BITS-1:0] ftime;
    logic [IDX_BITS-1:0]  idx;
  } tok_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                 clear;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [TIME_BITS-1:0] wr_val;
    logic [CNT_BITS-1:0]  n_act;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/efws_cell.sv]
// One worker cell: holds a free time and updates the passing search token.
`timescale 1ns / 1ps
`default_nettype none
module efws_cell (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [efws_pkg::IDX_BITS-1:0]   cell_idx,
  input  efws_pkg::cell_ctl_t             ctl,
  input  efws_pkg::tok_t                  tok_in,
  output efws_pkg::tok_t                  tok_out
);
  import efws_pkg::*;

  logic [TIME_BITS-1:0] time_r, time_nxt;
  tok_t                 tok_r, tok_nxt;
  logic                 active;
  logic                 take;

  assign active = {1'b0, cell_idx} < CNT_BITS'(ctl.n_act);
  // strict less-than keeps the lower index on ties
  assign take = active && ((cell_idx == '0) || (time_r < tok_in.ftime));

  always_comb begin
    tok_nxt     = tok_in;
    tok_nxt.vld = tok_in.vld;
    if (take) begin
      tok_nxt.ftime = time_r;
      tok_nxt.idx   = cell_idx;
    end
  end

  always_comb begin
    time_nxt = time_r;
    if (ctl.clear) begin
      time_nxt = '0;
    end else if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
      time_nxt = ctl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      time_r    <= time_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.ftime <= tok_nxt.ftime;
    tok_r.idx   <= tok_nxt.idx;
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

[rtl/earliest_free_worker_scheduler_top.sv]
// Top level: earliest-free-worker job scheduler built as a chain of worker cells.
//
// Usage:
//   Input: a job (duration, first_of_batch) is taken at a clock edge where
//   start is high and busy is low. busy stays high until the job's result has
//   been delivered and the chosen worker's free time written back.
//   Output: out_valid pulses for one cycle with the worker index and the job's
//   start time. The receiver cannot stall; the result is taken in that cycle.
//   Config: cfg_data (worker count, 7 bits) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Search:
//   A search token walks one cell per cycle through all MAX_WORKERS cells,
//   starting from the launch register; out_valid rises when it leaves the last
//   cell, and the result is taken and the free time written back in that cycle.
//   busy then falls, so no new job is taken before the last result is out.
//   Inactive cells just forward the token.
// Reset:
//   rst_n is synchronous, active low. All free times clear to zero, the worker
//   count returns to 1 and no job is in flight.
`timescale 1ns / 1ps
`default_nettype none
module earliest_free_worker_scheduler_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  efws_pkg::in_t                in_data,
  output logic                         out_valid,
  output efws_pkg::out_t               out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [efws_pkg::NW_BITS-1:0] cfg_data
);
  import efws_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [NW_BITS-1:0]   nw_r, nw_nxt;
  logic [DUR_BITS-1:0]  dur_r;
  logic                 launch_r, launch_nxt;
  logic                 accept;
  logic [CNT_BITS-1:0]  n_act;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] sat_val;
  tok_t                 tok [0:MAX_WORKERS];
  tok_t                 exit_tok;
  cell_ctl_t            ctl;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign exit_tok  = tok[MAX_WORKERS];

  // zero acts as one, above the slot count acts as the slot count
  always_comb begin
    if (nw_r == '0) begin
      n_act = CNT_BITS'(1);
    end else if ({{(32-NW_BITS){1'b0}}, nw_r} > 32'(MAX_WORKERS)) begin
      n_act = CNT_BITS'(MAX_WORKERS);
    end else begin
      n_act = CNT_BITS'(nw_r);
    end
  end

  assign sum     = {1'b0, exit_tok.ftime} + (TIME_BITS+1)'(dur_r);
  assign sat_val = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  always_comb begin
    ctl.clear  = accept && in_data.first_of_batch;
    ctl.wr_en  = exit_tok.vld;
    ctl.wr_idx = exit_tok.idx;
    ctl.wr_val = sat_val;
    ctl.n_act  = n_act;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (exit_tok.vld) begin
      busy_nxt = 1'b0;
    end
    launch_nxt = accept;
    nw_nxt     = (cfg_valid && cfg_ready) ? cfg_data : nw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      launch_r <= 1'b0;
      nw_r     <= NW_BITS'(1);
    end else begin
      busy_r   <= busy_nxt;
      launch_r <= launch_nxt;
      nw_r     <= nw_nxt;
    end
    if (accept) begin
      dur_r <= in_data.duration;
    end
  end

  assign tok[0] = '{vld: launch_r, ftime: '0, idx: '0};

  for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
    efws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_BITS'(k)),
      .ctl      (ctl),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  assign out_valid           = exit_tok.vld;
  assign out_data.worker     = WORKER_BITS'(exit_tok.idx);
  assign out_data.start_time = START_BITS'(exit_tok.ftime);

endmodule
`default_nettype wire

[verif/efws_checker.sv]
// Checker: predicts worker grants from observed transactions and compares the results.
`timescale 1ns / 1ps
module efws_checker (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire                        busy,
  input  efws_pkg::in_t              in_data,
  input  wire                        out_valid,
  input  efws_pkg::out_t             out_data,
  input  wire                        cfg_valid,
  input  wire                        cfg_ready,
  input  wire [efws_pkg::NW_BITS-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  import efws_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_SAT = '1;

  logic [TIME_BITS-1:0] free_at [MAX_WORKERS];
  logic [NW_BITS-1:0]   worker_count;
  out_t                 expected_grants [$];
  int                   mismatches = 0;

  // Place one job: earliest free worker wins, lowest index on ties.
  function automatic out_t schedule_job(in_t job);
    int                 active;
    int                 best;
    logic [TIME_BITS:0] sum;
    out_t               grant;
    if (worker_count == 0) begin
      active = 1;
    end else if (worker_count > MAX_WORKERS) begin
      active = MAX_WORKERS;
    end else begin
      active = int'(worker_count);
    end
    // clear covers every slot, active or not
    if (job.first_of_batch) begin
      foreach (free_at[i]) free_at[i] = '0;
    end
    best = 0;
    for (int i = 1; i < active; i++) begin
      if (free_at[i] < free_at[best]) best = i;
    end
    grant.worker     = WORKER_BITS'(best);
    grant.start_time = free_at[best][START_BITS-1:0];
    sum = {1'b0, free_at[best]} + (TIME_BITS+1)'(job.duration);
    free_at[best] = sum[TIME_BITS] ? TIME_SAT : sum[TIME_BITS-1:0];
    return grant;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      foreach (free_at[i]) free_at[i] = '0;
      worker_count = NW_BITS'(1);
      expected_grants.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result: expected none, got worker %0d start %0d",
                   $time, out_data.worker, out_data.start_time);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (out_data.worker !== want.worker) begin
            $display("%0t: worker mismatch: expected %0d, got %0d",
                     $time, want.worker, out_data.worker);
            mismatches++;
          end
          if (out_data.start_time !== want.start_time) begin
            $display("%0t: start_time mismatch: expected %0d, got %0d",
                     $time, want.start_time, out_data.start_time);
            mismatches++;
          end
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) worker_count = cfg_data;
      if (start === 1'b1 && busy === 1'b0) begin
        expected_grants = {expected_grants, schedule_job(in_data)};
      end
    end
    fail_count <= mismatches;
    pending    <= expected_grants.size();
  end

endmodule

[verif/tb_earliest_free_worker_scheduler_top.sv]
// Testbench top: clock, reset, job and worker-count stimulus, verdict.
`timescale 1ns / 1ps
module tb_earliest_free_worker_scheduler_top;
  import efws_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_t                in_data;
  logic               out_valid;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [NW_BITS-1:0] cfg_data;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 sender_idle_pct = 0;

  always #5 clk = ~clk;

  earliest_free_worker_scheduler_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  efws_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Returns at the edge that accepted the job; start is left high.
  task automatic send_job(input logic [DUR_BITS-1:0] dur, input logic first);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2 * MAX_WORKERS + 4)) @(posedge clk);
    end
    in_data <= '{duration: dur, first_of_batch: first};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_worker_count(input logic [NW_BITS-1:0] n);
    cfg_data  <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DUR_BITS-1:0] pick_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DUR_BITS'($urandom_range(15));
      5, 6:    return DUR_BITS'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NW_BITS-1:0] pick_count();
    case ($urandom_range(7))
      0:       return NW_BITS'(0);
      1:       return NW_BITS'(1);
      2:       return NW_BITS'(MAX_WORKERS);
      3:       return '1;
      4:       return NW_BITS'(MAX_WORKERS + 1);
      5:       return NW_BITS'($urandom_range(2, 8));
      default: return NW_BITS'($urandom_range(1, MAX_WORKERS));
    endcase
  endfunction

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single worker after reset, batch clear
    send_job(0, 1'b0);
    send_job(5, 1'b0);
    send_job(7, 1'b1);

    // four workers, ties and zero duration
    wait_idle();
    set_worker_count(NW_BITS'(4));
    send_job(10, 1'b1);
    send_job(20, 1'b0);
    send_job(30, 1'b0);
    send_job(40, 1'b0);
    send_job(1, 1'b0);
    send_job(0, 1'b0);

    // shrink mid-batch, then grow: idle workers keep their times
    wait_idle();
    set_worker_count(NW_BITS'(2));
    send_job(100, 1'b0);
    send_job(100, 1'b0);
    wait_idle();
    set_worker_count(NW_BITS'(4));
    send_job(0, 1'b0);
    send_job(0, 1'b0);

    // zero count acts as one
    wait_idle();
    set_worker_count(NW_BITS'(0));
    send_job('1, 1'b0);
    send_job(3, 1'b0);

    // count above max clamps
    wait_idle();
    set_worker_count('1);
    send_job('1, 1'b1);
    send_job(0, 1'b0);
    send_job(0, 1'b0);

    wait_idle();
    set_worker_count(NW_BITS'(MAX_WORKERS));
    send_job('1, 1'b0);
    send_job(1, 1'b1);

    // random batches; count changes without a clear exercise mid-batch behavior
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 83 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        wait_idle();
        set_worker_count(pick_count());
        repeat (42) send_job(pick_duration(), $urandom_range(11) == 0);
      end
    end

    wait_idle();
    repeat (MAX_WORKERS + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/efws_pkg.sv
rtl/efws_cell.sv
rtl/earliest_free_worker_scheduler_top.sv
verif/efws_checker.sv
verif/tb_earliest_free_worker_scheduler_top.sv
